>>> src/sle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and byte codes for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int LEN_W = 6;

	localparam logic [7:0] BYTE_CR    = 8'd13;
	localparam logic [7:0] BYTE_LF    = 8'd10;
	localparam logic [7:0] BYTE_BS    = 8'd8;
	localparam logic [7:0] BYTE_SPACE = 8'd32;
	localparam logic [7:0] BYTE_ESC   = 8'd27;
	localparam logic [7:0] BYTE_BRK   = 8'd91;
	localparam logic [7:0] BYTE_UP    = 8'd65;

	typedef enum logic [1:0] {
		KIND_ECHO     = 2'd0,
		KIND_LINE     = 2'd1,
		KIND_DONE     = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	// source of the output byte
	typedef enum logic [2:0] {
		BSEL_ZERO  = 3'd0,
		BSEL_RX    = 3'd1,
		BSEL_CR    = 3'd2,
		BSEL_LF    = 3'd3,
		BSEL_BS    = 3'd4,
		BSEL_SPACE = 3'd5,
		BSEL_RD    = 3'd6,
		BSEL_PEND  = 3'd7
	} bsel_t;

	typedef enum logic [2:0] {
		FILL_HOLD = 3'd0,
		FILL_INC  = 3'd1,
		FILL_DEC  = 3'd2,
		FILL_CLR  = 3'd3,
		FILL_CNT  = 3'd4
	} fill_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_CLR  = 2'd1,
		CNT_FILL = 2'd2,
		CNT_INC  = 2'd3
	} cnt_op_t;

	typedef struct packed {
		logic     latch_rx;
		logic     wr;
		logic     wr_term;
		logic     rd;
		logic     pend_load;
		logic     pend_clr;
		fill_op_t fill_op;
		cnt_op_t  cnt_op;
		logic     emit;
		kind_t    kind;
		bsel_t    bsel;
		logic     last;
	} cmd_t;

	typedef struct packed {
		logic is_cr;
		logic is_bs;
		logic is_esc;
		logic is_brk;
		logic is_up;
		logic full;
		logic cnt_lt_fill;
		logic cnt_more;
		logic cnt_lt_cap;
		logic rd_zero;
		logic pend_vld;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> src/serial_line_editor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_editor_top
// Terminal line editor: stores, echoes and edits received bytes, streams a
// finished line on carriage return and recalls the earlier line on ESC [ A.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  rx      | in        | rx_valid / rx_stall | rx_byte[7:0]
//  out     | out       | out_valid/out_stall | kind, out_byte, line_length, last
//
//  One byte at a time; rx_stall is high whenever the sequencer is not idle.
//  A carriage return streams the line with one store read and one beat per
//  line byte. A waiting beat holds the sequencer while out_stall is high.
//  Reset clears the store's per-entry valid bits at once; no clearing pass
//  is needed.
//
module serial_line_editor_top #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rx_valid,
	output logic                           rx_stall,
	input  wire logic [7:0]                rx_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [1:0]                     kind,
	output logic [7:0]                     out_byte,
	output logic [sle_pkg::LEN_W-1:0]      line_length,
	output logic                           last
);
	import sle_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: decode, escape tracking, beat ordering and the last flag
	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, indexes and the output beat register
	sle_datapath #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_byte    (out_byte),
		.line_length (line_length),
		.last        (last)
	);

endmodule
`default_nettype wire

>>> src/sle_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: decodes each received byte and steps out its result beats.
// ----------------------------------------------------------------------------
module sle_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rx_valid,
	output logic               rx_stall,
	input  wire sle_pkg::sts_t sts,
	output sle_pkg::cmd_t      cmd
);
	import sle_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_DEC  = 14'b00000000000010,
		S_ECHO = 14'b00000000000100,
		S_OVF  = 14'b00000000001000,
		S_CR   = 14'b00000000010000,
		S_LF   = 14'b00000000100000,
		S_LRD  = 14'b00000001000000,
		S_LEM  = 14'b00000010000000,
		S_DONE = 14'b00000100000000,
		S_BS1  = 14'b00001000000000,
		S_SP   = 14'b00010000000000,
		S_BS2  = 14'b00100000000000,
		S_RRD  = 14'b01000000000000,
		S_RCHK = 14'b10000000000000
	} state_t;

	// recall emit/finish reuse two extra states
	typedef enum logic [2:0] {
		R_NONE = 3'b001,
		R_EM   = 3'b010,
		R_FIN  = 3'b100
	} rsub_t;

	typedef enum logic [2:0] {
		ESC_NORM = 3'b001,
		ESC_SEEN = 3'b010,
		ESC_BRKT = 3'b100
	} esc_t;

	state_t state_q, state_n;
	rsub_t  rsub_q, rsub_n;
	esc_t   esc_q, esc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsub_q  <= R_NONE;
			esc_q   <= ESC_NORM;
		end else begin
			state_q <= state_n;
			rsub_q  <= rsub_n;
			esc_q   <= esc_n;
		end
	end

	assign rx_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		rsub_n  = rsub_q;
		esc_n   = esc_q;
		case (rsub_q)
			R_EM: begin
				// pending recall byte goes out, not last
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_ECHO;
					cmd.bsel      = BSEL_PEND;
					cmd.pend_load = 1'b1;
					cmd.cnt_op    = CNT_INC;
					rsub_n        = R_NONE;
					state_n       = S_RRD;
				end
			end
			R_FIN: begin
				if (!sts.pend_vld || sts.out_free) begin
					cmd.emit     = sts.pend_vld;
					cmd.kind     = KIND_ECHO;
					cmd.bsel     = BSEL_PEND;
					cmd.last     = 1'b1;
					cmd.pend_clr = 1'b1;
					cmd.fill_op  = FILL_CNT;
					rsub_n       = R_NONE;
					state_n      = S_IDLE;
				end
			end
			default: begin
				case (state_q)
					S_IDLE: begin
						if (rx_valid) begin
							cmd.latch_rx = 1'b1;
							state_n      = S_DEC;
						end
					end
					S_DEC: begin
						if (esc_q == ESC_BRKT) begin
							esc_n = ESC_NORM;
							if (sts.is_up) begin
								cmd.cnt_op   = CNT_FILL;
								cmd.pend_clr = 1'b1;
								state_n      = S_RRD;
							end else begin
								state_n = S_IDLE;
							end
						end else if (esc_q == ESC_SEEN) begin
							esc_n   = sts.is_brk ? ESC_BRKT : ESC_NORM;
							state_n = S_IDLE;
						end else if (sts.is_cr) begin
							cmd.wr      = 1'b1;
							cmd.wr_term = 1'b1;
							cmd.cnt_op  = CNT_CLR;
							state_n     = S_CR;
						end else if (sts.is_bs) begin
							cmd.fill_op = FILL_DEC;
							state_n     = S_BS1;
						end else if (sts.is_esc) begin
							esc_n   = ESC_SEEN;
							state_n = S_IDLE;
						end else if (sts.full) begin
							state_n = S_OVF;
						end else begin
							cmd.wr      = 1'b1;
							cmd.fill_op = FILL_INC;
							state_n     = S_ECHO;
						end
					end
					S_ECHO: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ECHO;
							cmd.bsel = BSEL_RX;
							cmd.last = 1'b1;
							state_n  = S_IDLE;
						end
					end
					S_OVF: begin
						if (sts.out_free) begin
							cmd.emit    = 1'b1;
							cmd.kind    = KIND_OVERFLOW;
							cmd.bsel    = BSEL_ZERO;
							cmd.last    = 1'b1;
							cmd.fill_op = FILL_CLR;
							state_n     = S_IDLE;
						end
					end
					S_CR: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ECHO;
							cmd.bsel = BSEL_CR;
							state_n  = S_LF;
						end
					end
					S_LF: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ECHO;
							cmd.bsel = BSEL_LF;
							state_n  = sts.cnt_lt_fill ? S_LRD : S_DONE;
						end
					end
					S_LRD: begin
						cmd.rd  = 1'b1;
						state_n = S_LEM;
					end
					S_LEM: begin
						if (sts.out_free) begin
							cmd.emit   = 1'b1;
							cmd.kind   = KIND_LINE;
							cmd.bsel   = BSEL_RD;
							cmd.cnt_op = CNT_INC;
							state_n    = sts.cnt_more ? S_LRD : S_DONE;
						end
					end
					S_DONE: begin
						if (sts.out_free) begin
							cmd.emit    = 1'b1;
							cmd.kind    = KIND_DONE;
							cmd.bsel    = BSEL_ZERO;
							cmd.last    = 1'b1;
							cmd.fill_op = FILL_CLR;
							state_n     = S_IDLE;
						end
					end
					S_BS1: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ECHO;
							cmd.bsel = BSEL_BS;
							state_n  = S_SP;
						end
					end
					S_SP: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ECHO;
							cmd.bsel = BSEL_SPACE;
							state_n  = S_BS2;
						end
					end
					S_BS2: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = KIND_ECHO;
							cmd.bsel = BSEL_BS;
							cmd.last = 1'b1;
							state_n  = S_IDLE;
						end
					end
					S_RRD: begin
						if (sts.cnt_lt_cap) begin
							cmd.rd  = 1'b1;
							state_n = S_RCHK;
						end else begin
							rsub_n = R_FIN;
						end
					end
					S_RCHK: begin
						if (sts.rd_zero) begin
							rsub_n = R_FIN;
						end else if (sts.pend_vld) begin
							rsub_n = R_EM;
						end else begin
							cmd.pend_load = 1'b1;
							cmd.cnt_op    = CNT_INC;
							state_n       = S_RRD;
						end
					end
					default: begin
						state_n = S_IDLE;
					end
				endcase
			end
		endcase
	end

endmodule
`default_nettype wire

>>> src/sle_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sle_datapath
// Line store, fill index, walk counter and the output beat register.
// ----------------------------------------------------------------------------
module sle_datapath #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire sle_pkg::cmd_t             cmd,
	output sle_pkg::sts_t                  sts,
	input  wire logic [7:0]                rx_byte,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [1:0]                     kind,
	output logic [7:0]                     out_byte,
	output logic [sle_pkg::LEN_W-1:0]      line_length,
	output logic                           last
);
	import sle_pkg::*;

	localparam int DEPTH = LINE_CAPACITY + 1;
	localparam int AW    = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_q;
	logic             rd_ok_q;
	logic [7:0]       rx_q;
	logic [7:0]       pend_q;
	logic             pend_vld_q;
	logic [AW-1:0]    fill_q;
	logic [AW-1:0]    cnt_q;
	logic             out_vld_q;
	logic [1:0]       kind_q;
	logic [7:0]       obyte_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;

	logic [7:0]       rd_byte;
	logic [7:0]       wr_data;
	logic [7:0]       sel_byte;

	assign rd_byte = rd_ok_q ? rd_q : 8'd0;
	assign wr_data = cmd.wr_term ? 8'd0 : rx_q;

	// line store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[fill_q] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= mem[cnt_q];
		end
	end

	// entries read as terminator until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				vld_q[fill_q] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_ok_q <= vld_q[cnt_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_rx) begin
			rx_q <= rx_byte;
		end
		if (cmd.pend_load) begin
			pend_q <= rd_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			case (cmd.fill_op)
				FILL_INC: fill_q <= fill_q + AW'(1);
				FILL_DEC: fill_q <= (fill_q != '0) ? fill_q - AW'(1) : fill_q;
				FILL_CLR: fill_q <= '0;
				FILL_CNT: fill_q <= cnt_q;
				default:  fill_q <= fill_q;
			endcase
			case (cmd.cnt_op)
				CNT_CLR:  cnt_q <= '0;
				CNT_FILL: cnt_q <= fill_q;
				CNT_INC:  cnt_q <= cnt_q + AW'(1);
				default:  cnt_q <= cnt_q;
			endcase
			if (cmd.pend_load) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.pend_clr) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (cmd.bsel)
			BSEL_RX:    sel_byte = rx_q;
			BSEL_CR:    sel_byte = BYTE_CR;
			BSEL_LF:    sel_byte = BYTE_LF;
			BSEL_BS:    sel_byte = BYTE_BS;
			BSEL_SPACE: sel_byte = BYTE_SPACE;
			BSEL_RD:    sel_byte = rd_byte;
			BSEL_PEND:  sel_byte = pend_q;
			default:    sel_byte = 8'd0;
		endcase
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q  <= cmd.kind;
			obyte_q <= sel_byte;
			len_q   <= (cmd.kind == KIND_DONE) ? LEN_W'(fill_q) : '0;
			last_q  <= cmd.last;
		end
	end

	assign out_valid   = out_vld_q;
	assign kind        = kind_q;
	assign out_byte    = obyte_q;
	assign line_length = len_q;
	assign last        = last_q;

	always_comb begin
		sts             = '0;
		sts.is_cr       = (rx_q == BYTE_CR);
		sts.is_bs       = (rx_q == BYTE_BS);
		sts.is_esc      = (rx_q == BYTE_ESC);
		sts.is_brk      = (rx_q == BYTE_BRK);
		sts.is_up       = (rx_q == BYTE_UP);
		sts.full        = (fill_q >= AW'(LINE_CAPACITY));
		sts.cnt_lt_fill = (cnt_q < fill_q);
		sts.cnt_more    = ((AW+1)'(cnt_q) + (AW+1)'(1)) < (AW+1)'(fill_q);
		sts.cnt_lt_cap  = (cnt_q < AW'(LINE_CAPACITY));
		sts.rd_zero     = (rd_byte == 8'd0);
		sts.pend_vld    = pend_vld_q;
		sts.out_free    = !out_vld_q || !out_stall;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= AW'(LINE_CAPACITY))
		else $error("fill index past capacity");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= AW'(LINE_CAPACITY))
		else $error("walk counter past capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_vld_q || !out_stall))
		else $error("beat overwrites a stalled result");

	a_rd_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (cnt_q < AW'(LINE_CAPACITY)))
		else $error("read beyond line area");

endmodule
`default_nettype wire

>>> tb/serial_line_editor_top_tb.sv
// ----------------------------------------------------------------------------
// serial_line_editor_top_tb
// Self-checking bench for the terminal line editor. Received bytes go in from
// a queue, and the bench keeps its own copy of the line store, fill index and
// escape state to work out every echo, line, line-done and overflow beat. Each
// output beat is checked against the oldest beat still pending. Both channels
// idle in random bursts.
// ----------------------------------------------------------------------------
module serial_line_editor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sle_pkg::*;

	localparam int CAP       = 32;     // line capacity of the block
	localparam int HALF_CLK  = 5;
	localparam int ITEMS     = 420;    // least number of input bytes in all
	localparam int TAIL      = 40;     // final stretch with no idling
	localparam int DOG_LIMIT = 2000;   // cycles with no beat on either side
	localparam int DRAIN     = 200;    // settle time after the last beat

	typedef enum logic [1:0] {
		ESC_IDLE,  // plain text
		ESC_SEEN,  // after ESC
		ESC_CSI    // after ESC [
	} esc_state_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
		logic             last;
	} beat_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             rx_valid  = 1'b0;
	logic             rx_stall;
	logic [7:0]       rx_byte   = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       kind;
	logic [7:0]       out_byte;
	logic [LEN_W-1:0] line_length;
	logic             last;

	serial_line_editor_top #(
		.LINE_CAPACITY(CAP)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.out_byte   (out_byte),
		.line_length(line_length),
		.last       (last)
	);

	always #(HALF_CLK) clk = ~clk;

	// ------------------------------------------------------------------------
	// Stimulus and expected beats
	// ------------------------------------------------------------------------
	logic [7:0]  rx_q[$];      // bytes still to send
	beat_t       want_q[$];    // output beats predicted, oldest first

	// shadow of the editor state
	logic [7:0]  line_mem [CAP+1];
	int unsigned fill_ptr  = 0;
	esc_state_t  esc_state = ESC_IDLE;

	int unsigned cyc_cnt   = 0;
	int unsigned quiet_cyc = 0;
	int unsigned miss_cnt  = 0;
	int unsigned rx_gap    = 0;
	int unsigned stall_left = 0;

	// byte that is stored and echoed as text, now and then a NUL
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		if (b == BYTE_CR || b == BYTE_BS || b == BYTE_ESC)
			b = b ^ 8'h40;
		if ($urandom_range(0, 15) == 0)
			b = 8'h00;
		return b;
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		rx_q.push_back(b);
	endtask

	task automatic queue_recall();
		queue_byte(BYTE_ESC);
		queue_byte(BYTE_BRK);
		queue_byte(BYTE_UP);
	endtask

	function automatic void want_beat(kind_t k, logic [7:0] d, logic [LEN_W-1:0] l);
		want_q.push_back('{k, d, l, 1'b0});
	endfunction

	// Advance the shadow state by one received byte; queue its output beats.
	task automatic edit_line(input logic [7:0] b);
		int unsigned n0;
		int unsigned walk;
		n0 = want_q.size();
		case (esc_state)
			ESC_CSI: begin
				// up arrow re-adopts the old line from the fill index on
				if (b == BYTE_UP) begin
					walk = fill_ptr;
					while (walk < CAP && line_mem[walk] != 8'h00) begin
						want_beat(KIND_ECHO, line_mem[walk], '0);
						walk++;
					end
					fill_ptr = walk;
				end
				esc_state = ESC_IDLE;
			end
			ESC_SEEN: begin
				esc_state = (b == BYTE_BRK) ? ESC_CSI : ESC_IDLE;
			end
			default: begin
				if (b == BYTE_CR) begin
					want_beat(KIND_ECHO, BYTE_CR, '0);
					want_beat(KIND_ECHO, BYTE_LF, '0);
					line_mem[fill_ptr] = 8'h00;
					for (int i = 0; i < fill_ptr; i++)
						want_beat(KIND_LINE, line_mem[i], '0);
					want_beat(KIND_DONE, 8'h00, LEN_W'(fill_ptr));
					fill_ptr = 0;
				end else if (b == BYTE_BS) begin
					if (fill_ptr > 0)
						fill_ptr--;
					want_beat(KIND_ECHO, BYTE_BS, '0);
					want_beat(KIND_ECHO, BYTE_SPACE, '0);
					want_beat(KIND_ECHO, BYTE_BS, '0);
				end else if (b == BYTE_ESC) begin
					esc_state = ESC_SEEN;
				end else if (fill_ptr >= CAP) begin
					// full store: byte lost, line restarts
					want_beat(KIND_OVERFLOW, 8'h00, '0);
					fill_ptr = 0;
				end else begin
					line_mem[fill_ptr] = b;
					fill_ptr++;
					want_beat(KIND_ECHO, b, '0);
				end
			end
		endcase
		if (want_q.size() > n0)
			want_q[want_q.size()-1].last = 1'b1;
	endtask

	// idling off near the end and in the tail of each cycle-count period
	function automatic bit jitter_on();
		return rx_q.size() > TAIL && (cyc_cnt % 600) < 400;
	endfunction

	task automatic log_miss(input string what, input beat_t w);
		miss_cnt++;
		if (miss_cnt <= 10)
			$display("%0t %s: want kind=%0d byte=%02h len=%0d last=%0b, %s",
				$time, what, w.kind, w.data, w.len, w.last,
				$sformatf("got kind=%0d byte=%02h len=%0d last=%0b",
					kind, out_byte, line_length, last));
	endtask

	// ------------------------------------------------------------------------
	// rx driver: predicts on every accepted beat, then loads the next byte
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte  <= 8'h00;
			rx_gap   <= 0;
		end else begin
			if (rx_valid && !rx_stall)
				edit_line(rx_byte);
			if (rx_valid && rx_stall) begin
				// stalled beat holds
			end else if (rx_gap > 0) begin
				rx_valid <= 1'b0;
				rx_gap   <= rx_gap - 1;
			end else if (rx_q.size() > 0 && jitter_on() && $urandom_range(0, 5) == 0) begin
				rx_valid <= 1'b0;
				rx_gap   <= $urandom_range(0, 5);   // start an idle burst
			end else if (rx_q.size() > 0) begin
				rx_valid <= 1'b1;
				rx_byte  <= rx_q.pop_front();
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// output monitor: checks each accepted beat, throttles with out_stall
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					log_miss("beat with nothing pending", '0);
				end else begin
					if (kind != want_q[0].kind || out_byte != want_q[0].data ||
					    line_length != want_q[0].len || last != want_q[0].last)
						log_miss("beat mismatch", want_q[0]);
					void'(want_q.pop_front());
				end
			end
			if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (jitter_on() && $urandom_range(0, 4) == 0) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 5);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// cycle count and watchdog on handshake activity
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_cnt   <= 0;
			quiet_cyc <= 0;
		end else begin
			cyc_cnt <= cyc_cnt + 1;
			if ((rx_valid && !rx_stall) || (out_valid && !out_stall))
				quiet_cyc <= 0;
			else
				quiet_cyc <= quiet_cyc + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned pick;
		int unsigned len;
		bit          timed_out;

		foreach (line_mem[i])
			line_mem[i] = 8'h00;

		// Opening: field extremes, NUL in text, backspace, CR, backspace at
		// the start of a line, recall stopping on a NUL, dropped escapes,
		// empty line, recall that finds nothing.
		queue_byte(8'h61);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h7F);
		queue_byte(8'h80);
		queue_byte(BYTE_BS);
		queue_byte(BYTE_CR);
		queue_byte(BYTE_BS);
		queue_recall();
		queue_byte(BYTE_ESC);
		queue_byte(8'h78);
		queue_byte(BYTE_ESC);
		queue_byte(BYTE_BRK);
		queue_byte(8'h42);
		queue_byte(BYTE_ESC);
		queue_byte(BYTE_ESC);
		queue_byte(BYTE_CR);
		queue_byte(BYTE_CR);
		queue_recall();

		// Full line: recall at capacity, overflow, recall of the full line up to
		// its first NUL (all 32 bytes if it has none), then that line out.
		for (int k = 0; k < CAP; k++)
			queue_byte(plain_byte());
		queue_recall();
		queue_byte(plain_byte());
		queue_recall();
		queue_byte(BYTE_CR);

		while (rx_q.size() < ITEMS - 1) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// typed line, mostly short, some near or past capacity
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 34)
				                                  : $urandom_range(1, 12);
				if ($urandom_range(0, 3) == 0)
					queue_recall();
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0)
						queue_byte(BYTE_BS);
					else
						queue_byte(plain_byte());
				end
				if ($urandom_range(0, 9) != 0)
					queue_byte(BYTE_CR);
			end else if (pick < 65) begin
				// edit a recalled line
				queue_recall();
				len = $urandom_range(0, 4);
				for (int k = 0; k < len; k++)
					queue_byte(($urandom_range(0, 1) == 0) ? BYTE_BS : plain_byte());
				queue_byte(BYTE_CR);
			end else if (pick < 75) begin
				len = $urandom_range(1, 5);
				for (int k = 0; k < len; k++)
					queue_byte(BYTE_BS);
			end else if (pick < 85) begin
				// escape sequences, mostly broken ones
				queue_byte(BYTE_ESC);
				if ($urandom_range(0, 1) == 0)
					queue_byte(BYTE_BRK);
				queue_byte(8'($urandom_range(0, 255)));
			end else begin
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					queue_byte(8'($urandom_range(0, 255)));
			end
		end
		queue_byte(BYTE_CR);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		timed_out = 1'b0;
		while (!timed_out && (rx_q.size() > 0 || rx_valid || want_q.size() > 0)) begin
			@(posedge clk);
			timed_out = (quiet_cyc >= DOG_LIMIT);
		end
		if (!timed_out)
			repeat (DRAIN) @(posedge clk);

		if (want_q.size() > 0)
			$display("%0d expected beats never arrived", want_q.size());
		if (!timed_out && miss_cnt == 0 && want_q.size() == 0)
			$display("serial_line_editor_top_tb OK");
		else
			$display("serial_line_editor_top_tb NOT OK");
		$finish;
	end

endmodule
